/* design/tlpt_pkg.sv */
// shared constants, codes and controller/datapath command types for the page table manager
package tlpt_pkg;

  // number of second-level tables in the pool
  localparam int unsigned TablePoolSize = 64;

  localparam int unsigned IdxW     = 10;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned FlagsW   = 12;
  localparam int unsigned TnumW    = (TablePoolSize > 1) ? $clog2(TablePoolSize) : 1;
  localparam int unsigned CntW     = $clog2(TablePoolSize + 1);
  localparam int unsigned DirW     = TnumW + 1;
  localparam int unsigned DirDepth = 1 << IdxW;
  localparam int unsigned TblAddrW = TnumW + IdxW;
  localparam int unsigned TblDepth = 1 << TblAddrW;

  localparam logic [AddrW-1:0] FrameMask = 32'hFFFF_F000;

  typedef enum logic [1:0] {
    OP_MAP    = 2'd0,
    OP_UNMAP  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_POOL_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_DECIDE,
    S_LOOK
  } state_e;

  typedef struct packed {
    logic    in_take;
    logic    clr_wr;
    logic    dir_rd;
    logic    dir_alloc;
    logic    tbl_wr;
    logic    tbl_zero;
    logic    tbl_rd;
    logic    res_load;
    logic    res_from_tbl;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       present;
    logic       pool_full;
    logic       entry_nz;
    logic       clr_last;
    logic       res_busy;
  } sts_t;

endpackage

/* design/tlpt_intf.sv */
// request and response channel interfaces of the page table manager
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] virtual_address;
  logic [31:0] physical_address;
  logic [11:0] entry_flags;

  modport source (
    output valid, operation, virtual_address, physical_address, entry_flags,
    input  ready
  );
  modport sink (
    input  valid, operation, virtual_address, physical_address, entry_flags,
    output ready
  );
endinterface

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] frame_address;

  modport source (
    output valid, status, frame_address,
    input  ready
  );
  modport sink (
    input  valid, status, frame_address,
    output ready
  );
endinterface

/* design/tlpt_ram.sv */
// generic single-write single-read ram with registered read data
module tlpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tlpt_ctrl.sv */
// sequencing state machine: clear sweep, directory read, table access, result load
module tlpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tlpt_pkg::sts_t sts_i,
  output tlpt_pkg::cmd_t cmd_o
);
  import tlpt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DIR;
      end
      S_DIR: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.op == OP_LOOKUP && sts_i.present) begin
          state_d = S_LOOK;
        end else if (!sts_i.res_busy) begin
          state_d = S_IDLE;
        end
      end
      S_LOOK: begin
        if (!sts_i.res_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_take = in_valid_i;
      end
      S_DIR: begin
        cmd_o.dir_rd = 1'b1;
      end
      S_DECIDE: begin
        if (sts_i.op == OP_LOOKUP && sts_i.present) begin
          cmd_o.tbl_rd = 1'b1;
        end else if (!sts_i.res_busy) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          unique case (sts_i.op)
            OP_MAP: begin
              if (sts_i.present) begin
                cmd_o.tbl_wr = 1'b1;
              end else if (sts_i.pool_full) begin
                cmd_o.res_status = ST_POOL_EMPTY;
              end else begin
                cmd_o.dir_alloc = 1'b1;
                cmd_o.tbl_wr    = 1'b1;
              end
            end
            OP_UNMAP: begin
              cmd_o.tbl_wr   = sts_i.present;
              cmd_o.tbl_zero = 1'b1;
            end
            OP_LOOKUP: begin
              // no table behind this directory entry
              cmd_o.res_status = ST_NOT_MAPPED;
            end
            default: begin
              cmd_o.res_status = ST_OK;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (!sts_i.res_busy) begin
          cmd_o.res_load = 1'b1;
          if (sts_i.entry_nz) begin
            cmd_o.res_from_tbl = 1'b1;
            cmd_o.res_status   = ST_OK;
          end else begin
            cmd_o.res_status = ST_NOT_MAPPED;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* design/tlpt_dp.sv */
// datapath: request registers, directory and table memories, allocation count, result register
module tlpt_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   operation_i,
  input  logic [tlpt_pkg::AddrW-1:0]   virtual_address_i,
  input  logic [tlpt_pkg::AddrW-1:0]   physical_address_i,
  input  logic [tlpt_pkg::FlagsW-1:0]  entry_flags_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [tlpt_pkg::AddrW-1:0]   frame_address_o,
  input  tlpt_pkg::cmd_t               cmd_i,
  output tlpt_pkg::sts_t               sts_o
);
  import tlpt_pkg::*;

  logic [1:0]        op_q;
  logic [AddrW-1:0]  va_q;
  logic [AddrW-1:0]  pa_q;
  logic [FlagsW-1:0] flags_q;

  logic [CntW-1:0]     alloc_q;
  logic [TblAddrW-1:0] clr_cnt_q;

  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic [AddrW-1:0] out_frame_q;

  logic [IdxW-1:0]     dir_idx;
  logic [IdxW-1:0]     tbl_idx;
  logic [DirW-1:0]     dir_rdata;
  logic [TnumW-1:0]    dir_tnum;
  logic [TnumW-1:0]    alloc_tnum;
  logic                dir_we;
  logic [IdxW-1:0]     dir_waddr;
  logic [DirW-1:0]     dir_wdata;
  logic                tbl_we;
  logic [TblAddrW-1:0] tbl_waddr;
  logic [AddrW-1:0]    tbl_wdata;
  logic [TblAddrW-1:0] tbl_raddr;
  logic [AddrW-1:0]    tbl_rdata;

  assign dir_idx    = va_q[31:22];
  assign tbl_idx    = va_q[21:12];
  assign dir_tnum   = dir_rdata[TnumW-1:0];
  assign alloc_tnum = alloc_q[TnumW-1:0];

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      op_q    <= operation_i;
      va_q    <= virtual_address_i;
      pa_q    <= physical_address_i;
      flags_q <= entry_flags_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q   <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.dir_alloc) alloc_q <= alloc_q + CntW'(1);
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + TblAddrW'(1);
    end
  end

  // directory: present bit over table number
  assign dir_we    = cmd_i.clr_wr | cmd_i.dir_alloc;
  assign dir_waddr = cmd_i.clr_wr ? clr_cnt_q[IdxW-1:0] : dir_idx;
  assign dir_wdata = cmd_i.clr_wr ? '0 : {1'b1, alloc_tnum};

  tlpt_ram #(
    .WIDTH (DirW),
    .DEPTH (DirDepth)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (cmd_i.dir_rd),
    .raddr_i (dir_idx),
    .rdata_o (dir_rdata)
  );

  // second-level tables, addressed by table number and table index
  assign tbl_we    = cmd_i.clr_wr | cmd_i.tbl_wr;
  assign tbl_waddr = cmd_i.clr_wr ? clr_cnt_q
                                  : {(cmd_i.dir_alloc ? alloc_tnum : dir_tnum), tbl_idx};
  assign tbl_wdata = (cmd_i.clr_wr | cmd_i.tbl_zero) ? '0
                   : ((pa_q & FrameMask) | {{(AddrW-FlagsW){1'b0}}, flags_q});
  assign tbl_raddr = {dir_tnum, tbl_idx};

  tlpt_ram #(
    .WIDTH (AddrW),
    .DEPTH (TblDepth)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (cmd_i.tbl_rd),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_frame_q  <= cmd_i.res_from_tbl ? (tbl_rdata & FrameMask) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign frame_address_o = out_frame_q;

  assign sts_o.op        = op_q;
  assign sts_o.present   = dir_rdata[DirW-1];
  assign sts_o.pool_full = (alloc_q >= CntW'(TablePoolSize));
  assign sts_o.entry_nz  = (tbl_rdata != '0);
  assign sts_o.clr_last  = (clr_cnt_q == '1);
  assign sts_o.res_busy  = out_valid_q & ~out_ready_i;

endmodule

/* design/two_level_page_table_manager.sv */
// two-level page table manager: map, unmap and look up 4 KiB pages
//
// requests arrive on in_i (valid/ready), one response per request leaves on
// out_o (valid/ready). a request carries operation, virtual address, physical
// address and entry flags; the response carries status and frame address.
// one request is in flight at a time. a request is taken in one cycle, its
// directory entry is read in the next, and then the table entry, if any, is
// read, or written once the output register is free; a look up through a
// table takes a further step because the table read depends on the directory
// read. both memories have one read and one write port with registered read
// data.
// the response sits in an output register, so a new request is taken while a
// response is still waiting; if the receiver stalls, the next request holds
// at its final step until the output register frees.
// after reset the block sweeps both memories to zero, one table entry per
// cycle over TblDepth entries (65536 with a pool of 64 tables); in_i.ready
// stays low during the sweep. the table allocation count restarts at zero.
module two_level_page_table_manager (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlpt_req_if.sink   in_i,
  tlpt_rsp_if.source out_o
);
  import tlpt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlpt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .operation_i        (in_i.operation),
    .virtual_address_i  (in_i.virtual_address),
    .physical_address_i (in_i.physical_address),
    .entry_flags_i      (in_i.entry_flags),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .status_o           (out_o.status),
    .frame_address_o    (out_o.frame_address),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule

/* design/tlpt_chk.sv */
// port-level checks for the page table manager and their bind
module tlpt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [31:0] out_frame_i
);
  import tlpt_pkg::*;

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_frame_i))
    else $error("response changed while stalled");

  // one transaction in flight: no request is taken right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken back to back");

  a_frame_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_frame_i[11:0] == 12'd0)
    else $error("frame address not page aligned");

  a_frame_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_frame_i == 32'd0)
    else $error("nonzero frame with failing status");

endmodule

bind two_level_page_table_manager tlpt_chk u_tlpt_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_frame_i  (out_o.frame_address)
);

/* bench/page_table_checker.sv */
// checker for the page table manager: predicts each response and compares it on the output channel
module page_table_checker
  import tlpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tlpt_req_if         req_i,
  tlpt_rsp_if         rsp_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  typedef struct {
    status_e          status;
    logic [AddrW-1:0] frame;
  } page_result_t;

  logic             dir_present [DirDepth];
  logic [TnumW-1:0] dir_table   [DirDepth];
  logic [AddrW-1:0] table_mem   [TblDepth];
  int unsigned      tables_used;
  int unsigned      mismatch_cnt;
  page_result_t     pending_results [$];

  // tables are cleared when allocated, so table_mem needs no reset
  function automatic page_result_t apply_page_op(logic [1:0] op, logic [AddrW-1:0] va,
                                                 logic [AddrW-1:0] pa,
                                                 logic [FlagsW-1:0] flags);
    page_result_t    res;
    logic [IdxW-1:0] di;
    logic [IdxW-1:0] ti;
    res.status = ST_OK;
    res.frame  = '0;
    di = va[31:22];
    ti = va[21:12];
    case (op)
      OP_MAP: begin
        if (!dir_present[di]) begin
          if (tables_used >= TablePoolSize) begin
            res.status = ST_POOL_EMPTY;
          end else begin
            for (int k = 0; k < (1 << IdxW); k++)
              table_mem[{tables_used[TnumW-1:0], k[IdxW-1:0]}] = '0;
            dir_table[di]   = tables_used[TnumW-1:0];
            dir_present[di] = 1'b1;
            tables_used++;
          end
        end
        if (res.status == ST_OK)
          table_mem[{dir_table[di], ti}] = (pa & FrameMask) | {{(AddrW-FlagsW){1'b0}}, flags};
      end
      OP_UNMAP: begin
        if (dir_present[di]) table_mem[{dir_table[di], ti}] = '0;
      end
      OP_LOOKUP: begin
        res.status = ST_NOT_MAPPED;
        // a zero entry reads as not mapped, even if it was mapped that way
        if (dir_present[di] && table_mem[{dir_table[di], ti}] != '0) begin
          res.status = ST_OK;
          res.frame  = table_mem[{dir_table[di], ti}] & FrameMask;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t want;
    if (!rst_ni) begin
      for (int d = 0; d < DirDepth; d++) dir_present[d] = 1'b0;
      tables_used   = 0;
      mismatch_cnt  = 0;
      pending_results.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected response transaction: status %0d frame %08h",
                     rsp_i.status, rsp_i.frame_address);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.status !== want.status || rsp_i.frame_address !== want.frame) begin
            if (mismatch_cnt < 10)
              $display("response mismatch: expected status %0d frame %08h, got status %0d frame %08h",
                       want.status, want.frame, rsp_i.status, rsp_i.frame_address);
            mismatch_cnt++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        pending_results.push_back(apply_page_op(req_i.operation, req_i.virtual_address,
                                                req_i.physical_address, req_i.entry_flags));
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

/* bench/testbench.sv */
// top of the page table manager bench: clock, reset, request stimulus and response back-pressure
module testbench;
  import tlpt_pkg::*;

  localparam logic [1:0]  OpUnused      = 2'd3;
  localparam int unsigned RandomItems   = 1600;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit    = 500000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  bit          hold_off_req = 1'b0;

  tlpt_req_if req_ch ();
  tlpt_rsp_if rsp_ch ();

  two_level_page_table_manager DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  page_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // holds valid high until the transaction is taken
  task automatic offer_request(input logic [1:0] op, input logic [AddrW-1:0] va,
                               input logic [AddrW-1:0] pa, input logic [FlagsW-1:0] flags);
    req_ch.valid            <= 1'b1;
    req_ch.operation        <= op;
    req_ch.virtual_address  <= va;
    req_ch.physical_address <= pa;
    req_ch.entry_flags      <= flags;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic idle_requests(input int unsigned cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // receiver: random stalls, ready stretches, and a long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(10, 50)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [IdxW-1:0]   dir_cand [96];
    logic [IdxW-1:0]   tbl_cand [8];
    logic [1:0]        op;
    logic [AddrW-1:0]  va;
    logic [AddrW-1:0]  pa;
    logic [FlagsW-1:0] flags;
    logic [IdxW-1:0]   ti;
    int unsigned       item;
    int unsigned       burst;
    int unsigned       span;
    int unsigned       sel;
    bit                drained_once;

    rst_ni                  <= 1'b0;
    req_ch.valid            <= 1'b0;
    req_ch.operation        <= OP_MAP;
    req_ch.virtual_address  <= '0;
    req_ch.physical_address <= '0;
    req_ch.entry_flags      <= '0;
    dir_cand[0] = '0;
    dir_cand[1] = '1;
    for (int k = 2; k < 96; k++) dir_cand[k] = IdxW'($urandom_range(0, 1023));
    tbl_cand[0] = '0;
    tbl_cand[1] = '1;
    for (int k = 2; k < 8; k++) tbl_cand[k] = IdxW'($urandom_range(0, 1023));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no table yet for directory 0
    offer_request(OP_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
    offer_request(OP_UNMAP,  32'h0000_0000, 32'h0, 12'h000);
    offer_request(OpUnused,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    offer_request(OP_MAP,    32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    offer_request(OP_LOOKUP, 32'h0000_0FFF, 32'h0, 12'h000);
    idle_requests(3);
    // frame 0 with no flags leaves a zero entry
    offer_request(OP_MAP,    32'h0000_0000, 32'h0000_0000, 12'h000);
    offer_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    offer_request(OP_MAP,    32'h0000_0123, 32'h1234_5678, 12'h000);
    offer_request(OP_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
    idle_requests(1);
    offer_request(OP_MAP,    32'hFFFF_FFFF, 32'h0000_0FFF, 12'h001);
    offer_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h000);
    offer_request(OP_UNMAP,  32'hFFFF_F000, 32'h0, 12'h000);
    offer_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h000);
    offer_request(OP_LOOKUP, 32'h003F_F000, 32'h0, 12'h000);
    offer_request(OP_MAP,    32'hFFC0_0000, 32'hFFFF_F000, 12'hAAA);
    offer_request(OP_LOOKUP, 32'hFFC0_0FFF, 32'h0, 12'h000);
    offer_request(OpUnused,  32'h0000_0000, 32'h0, 12'h000);
    offer_request(OP_LOOKUP, 32'h0000_0000, 32'h0, 12'h000);
    drain_responses();

    item = 0;
    drained_once = 1'b0;
    while (item < RandomItems) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && item < RandomItems; b++) begin
        sel = $urandom_range(0, 99);
        if (sel < 40)      op = OP_MAP;
        else if (sel < 75) op = OP_LOOKUP;
        else if (sel < 95) op = OP_UNMAP;
        else               op = OpUnused;
        // the directory working set widens over the run to all 96 candidates, more than the pool of 64 tables holds
        span = (item / 12 + 7 > 95) ? 95 : item / 12 + 7;
        ti = ($urandom_range(0, 9) == 0) ? IdxW'($urandom_range(0, 1023))
                                         : tbl_cand[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0)
          va = $urandom();
        else
          va = {dir_cand[$urandom_range(0, span)], ti, 12'($urandom_range(0, 4095))};
        pa    = $urandom();
        flags = FlagsW'($urandom_range(0, 4095));
        if ($urandom_range(0, 29) == 0) begin
          pa[31:12] = '0;
          flags     = '0;
        end
        offer_request(op, va, pa, flags);
        item++;
        if (item == 400 || item == 1100) hold_off_req = 1'b1;
      end
      if (item >= 800 && !drained_once) begin
        drain_responses();
        drained_once = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_requests($urandom_range(1, 8));
      end
    end

    drain_responses();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tlpt_pkg.sv
design/tlpt_intf.sv
design/tlpt_ram.sv
design/tlpt_ctrl.sv
design/tlpt_dp.sv
design/two_level_page_table_manager.sv
design/tlpt_chk.sv
bench/page_table_checker.sv
bench/testbench.sv
